// ===== hw/rtl/gregorian_date_offset_macros.svh =====
// ----------------------------------------------------------------------------
// gregorian_date_offset_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_OFFSET_MACROS_SVH
`define GREGORIAN_DATE_OFFSET_MACROS_SVH

// checked only while out of reset
`define GDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define GDO_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/gdo_pkg.sv =====
// ----------------------------------------------------------------------------
// gdo_pkg
// types, constants and calendar helpers for the date offset block
// ----------------------------------------------------------------------------
`default_nettype none

package gdo_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned OFF_W   = 17;
    localparam int unsigned DD_W    = 18;
    localparam int unsigned CENT_W  = 7;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
    localparam logic [MONTH_W-1:0] JANUARY   = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER  = 4'd12;
    localparam logic [DAY_W-1:0]   DEC_DAYS  = 5'd31;

    // y / 100 == (y * 5243) >> 19 for every y up to 9999
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = YEAR_W + 13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CLAMP,
        S_WALK,
        S_FINISH
    } t_gdo_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic clamp;
        logic step;
        logic push;
    } t_gdo_cmd;

    typedef struct packed {
        logic walk_done;
    } t_gdo_stat;

    // leap from the year mod 100 and the century mod 4
    function automatic logic is_leap(input logic [CENT_W-1:0] rem100,
                                     input logic [1:0] cent4);
        logic r;
        r = ((rem100[1:0] == 2'd0) && (rem100 != '0)) ||
            ((rem100 == '0) && (cent4 == 2'd0));
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                    n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gdo_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdo_ctrl
// sequencer: load, year split, clamp, month walk, hand-off to output
// ----------------------------------------------------------------------------
`default_nettype none

module gdo_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire gdo_pkg::t_gdo_stat i_stat,
    output gdo_pkg::t_gdo_cmd       o_cmd
);

    gdo_pkg::t_gdo_state r_state, n_state;
    logic                r_out_valid, n_out_valid;
    logic                w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gdo_pkg::S_IDLE:   if (i_in_valid) n_state = gdo_pkg::S_PREP;
            gdo_pkg::S_PREP:   n_state = gdo_pkg::S_CLAMP;
            gdo_pkg::S_CLAMP:  n_state = gdo_pkg::S_WALK;
            gdo_pkg::S_WALK:   if (i_stat.walk_done) n_state = gdo_pkg::S_FINISH;
            gdo_pkg::S_FINISH: if (w_slot_free) n_state = gdo_pkg::S_IDLE;
            default:           n_state = gdo_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            gdo_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            gdo_pkg::S_PREP:   o_cmd.prep  = 1'b1;
            gdo_pkg::S_CLAMP:  o_cmd.clamp = 1'b1;
            gdo_pkg::S_WALK:   o_cmd.step  = !i_stat.walk_done;
            gdo_pkg::S_FINISH: o_cmd.push  = w_slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gdo_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/gdo_datapath.sv =====
// ----------------------------------------------------------------------------
// gdo_datapath
// date registers, leap tracking, one month carry or borrow per step
// ----------------------------------------------------------------------------
`default_nettype none

module gdo_datapath (
    input  wire logic                                  i_clk,
    input  wire gdo_pkg::t_gdo_cmd                     i_cmd,
    input  wire logic [gdo_pkg::YEAR_W-1:0]            i_year,
    input  wire logic [gdo_pkg::MONTH_W-1:0]           i_month,
    input  wire logic [gdo_pkg::DAY_W-1:0]             i_day,
    input  wire logic signed [gdo_pkg::OFF_W-1:0]      i_offset,
    output gdo_pkg::t_gdo_stat                         o_stat,
    output logic [gdo_pkg::YEAR_W-1:0]                 o_year,
    output logic [gdo_pkg::MONTH_W-1:0]                o_month,
    output logic [gdo_pkg::DAY_W-1:0]                  o_day,
    output logic                                       o_start_valid,
    output logic                                       o_range_error
);

    localparam int unsigned YW = gdo_pkg::YEAR_W;
    localparam int unsigned MW = gdo_pkg::MONTH_W;
    localparam int unsigned DW = gdo_pkg::DAY_W;
    localparam int unsigned CW = gdo_pkg::CENT_W;
    localparam int unsigned XW = gdo_pkg::DD_W;

    logic [YW-1:0]        r_year;
    logic                 r_year_ok;
    logic [CW-1:0]        r_cent;
    logic [CW-1:0]        r_rem;
    logic [1:0]           r_cent4;
    logic [MW-1:0]        r_month;
    logic [DW-1:0]        r_day_raw;
    logic signed [16:0]   r_off;
    logic signed [XW-1:0] r_dd;
    logic                 r_fwd;
    logic                 r_valid;
    logic                 r_err;

    logic [YW-1:0]        r_o_year;
    logic [MW-1:0]        r_o_month;
    logic [DW-1:0]        r_o_day;
    logic                 r_o_valid;
    logic                 r_o_err;

    logic [YW-1:0]                 w_year_c;
    logic [gdo_pkg::PROD_W-1:0]    w_prod;
    logic [YW-1:0]                 w_rem_full;
    logic                          w_leap;
    logic [MW-1:0]                 w_mc;
    logic [DW-1:0]                 w_clen;
    logic [DW-1:0]                 w_dc;
    logic                          w_start_ok;
    logic [DW-1:0]                 w_len;
    logic [MW-1:0]                 w_prev_m;
    logic [DW-1:0]                 w_prev_len;
    logic signed [XW-1:0]          w_len_x;
    logic                          w_fits;

    // load: clamp year and estimate the century by reciprocal multiply
    assign w_year_c = (i_year > gdo_pkg::MAX_YEAR) ? gdo_pkg::MAX_YEAR : i_year;
    assign w_prod   = gdo_pkg::PROD_W'(w_year_c) * gdo_pkg::PROD_W'(gdo_pkg::RECIP_100);

    assign w_rem_full = r_year - (YW'(r_cent) * YW'(7'd100));

    assign w_leap = gdo_pkg::is_leap(r_rem, r_cent4);

    // clamp stage, r_month still holds the raw month here
    always_comb begin
        w_mc = r_month;
        if (r_month == '0) begin
            w_mc = gdo_pkg::JANUARY;
        end else if (r_month > gdo_pkg::DECEMBER) begin
            w_mc = gdo_pkg::DECEMBER;
        end
    end
    assign w_clen = gdo_pkg::month_len(w_mc, w_leap);
    assign w_dc   = (r_day_raw == '0) ? DW'(1) :
                    (r_day_raw > w_clen) ? w_clen : r_day_raw;
    assign w_start_ok = r_year_ok && (r_month != '0) && (r_month <= gdo_pkg::DECEMBER) &&
                        (r_day_raw != '0) && (r_day_raw <= w_clen);

    // walk stage
    assign w_len      = gdo_pkg::month_len(r_month, w_leap);
    assign w_prev_m   = r_month - MW'(1);
    assign w_prev_len = gdo_pkg::month_len(w_prev_m, w_leap);
    assign w_len_x    = $signed({{(XW-DW){1'b0}}, w_len});
    assign w_fits     = r_fwd ? (r_dd <= w_len_x) : (r_dd > 0);

    assign o_stat.walk_done = r_err || w_fits;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year    <= w_year_c;
            r_year_ok <= (i_year <= gdo_pkg::MAX_YEAR);
            r_cent    <= w_prod[gdo_pkg::RECIP_SHIFT +: CW];
            r_month   <= i_month;
            r_day_raw <= i_day;
            r_off     <= i_offset;
        end
        if (i_cmd.prep) begin
            r_rem   <= w_rem_full[CW-1:0];
            r_cent4 <= r_cent[1:0];
        end
        if (i_cmd.clamp) begin
            r_month <= w_mc;
            r_dd    <= $signed({{(XW-DW){1'b0}}, w_dc}) + XW'(r_off);
            r_fwd   <= !r_off[16];
            r_valid <= w_start_ok;
            r_err   <= 1'b0;
        end
        if (i_cmd.step) begin
            if (r_fwd) begin
                r_dd <= r_dd - w_len_x;
                if (r_month == gdo_pkg::DECEMBER) begin
                    if (r_year == gdo_pkg::MAX_YEAR) begin
                        r_err <= 1'b1;
                    end else begin
                        r_month <= gdo_pkg::JANUARY;
                        r_year  <= r_year + YW'(1);
                        if (r_rem == CW'(99)) begin
                            r_rem   <= '0;
                            r_cent4 <= r_cent4 + 2'd1;
                        end else begin
                            r_rem <= r_rem + CW'(1);
                        end
                    end
                end else begin
                    r_month <= r_month + MW'(1);
                end
            end else begin
                if (r_month == gdo_pkg::JANUARY) begin
                    if (r_year == '0) begin
                        r_err <= 1'b1;
                    end else begin
                        // december has 31 days in any year
                        r_month <= gdo_pkg::DECEMBER;
                        r_year  <= r_year - YW'(1);
                        r_dd    <= r_dd + $signed({{(XW-DW){1'b0}}, gdo_pkg::DEC_DAYS});
                        if (r_rem == '0) begin
                            r_rem   <= CW'(99);
                            r_cent4 <= r_cent4 - 2'd1;
                        end else begin
                            r_rem <= r_rem - CW'(1);
                        end
                    end
                end else begin
                    r_month <= w_prev_m;
                    r_dd    <= r_dd + $signed({{(XW-DW){1'b0}}, w_prev_len});
                end
            end
        end
        if (i_cmd.push) begin
            r_o_valid <= r_valid;
            r_o_err   <= r_err;
            if (r_err && r_fwd) begin
                r_o_year  <= gdo_pkg::MAX_YEAR;
                r_o_month <= gdo_pkg::DECEMBER;
                r_o_day   <= gdo_pkg::DEC_DAYS;
            end else if (r_err) begin
                r_o_year  <= '0;
                r_o_month <= gdo_pkg::JANUARY;
                r_o_day   <= DW'(1);
            end else begin
                r_o_year  <= r_year;
                r_o_month <= r_month;
                r_o_day   <= r_dd[DW-1:0];
            end
        end
    end

    assign o_year        = r_o_year;
    assign o_month       = r_o_month;
    assign o_day         = r_o_day;
    assign o_start_valid = r_o_valid;
    assign o_range_error = r_o_err;

endmodule

`default_nettype wire

// ===== hw/rtl/gregorian_date_offset.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_offset
// adds a signed day offset to a gregorian date, one month per cycle
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   40     start date and day offset
//  m_axis    out  32     shifted date and status flags
//
//  from acceptance to m_axis_tvalid an item crosses n month boundaries, with n
//  up to about 2160 for the widest offset; the month walk loop does one carry
//  or borrow each cycle
//  one item is in work at a time; the result waits in an output register
//  and the next item is taken while it waits; reset is synchronous, active low
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_offset (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [13:0] start_year, [17:14] start_month, [22:18] start_day, [39:23] offset_days
    input  wire logic [gdo_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [13:0] result_year, [17:14] result_month, [22:18] result_day,
    // [23] start_valid, [24] range_error, [31:25] zero
    output logic [gdo_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    gdo_pkg::t_gdo_cmd             w_cmd;
    gdo_pkg::t_gdo_stat            w_stat;
    logic [gdo_pkg::YEAR_W-1:0]    w_year;
    logic [gdo_pkg::MONTH_W-1:0]   w_month;
    logic [gdo_pkg::DAY_W-1:0]     w_day;
    logic                          w_start_valid;
    logic                          w_range_error;

    gdo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    gdo_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_year        (s_axis_tdata[13:0]),
        .i_month       (s_axis_tdata[17:14]),
        .i_day         (s_axis_tdata[22:18]),
        .i_offset      ($signed(s_axis_tdata[39:23])),
        .o_stat        (w_stat),
        .o_year        (w_year),
        .o_month       (w_month),
        .o_day         (w_day),
        .o_start_valid (w_start_valid),
        .o_range_error (w_range_error)
    );

    assign m_axis_tdata = {7'd0, w_range_error, w_start_valid, w_day, w_month, w_year};

endmodule

`default_nettype wire

// ===== hw/rtl/gdo_checker.sv =====
// ----------------------------------------------------------------------------
// gdo_port_checks
// port-level checks on the date offset block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "gregorian_date_offset_macros.svh"

module gdo_port_checks (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [39:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    `GDO_ASSERT_RST(a_rst_no_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    `GDO_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

    `GDO_ASSERT(a_out_range, m_axis_tvalid |-> (m_axis_tdata[13:0] <= 14'd9999) && (m_axis_tdata[17:14] >= 4'd1) && (m_axis_tdata[17:14] <= 4'd12) && (m_axis_tdata[22:18] != 5'd0), "result date out of range")

    `GDO_ASSERT(a_err_clamp, m_axis_tvalid && m_axis_tdata[24] |-> (m_axis_tdata[22:0] == {5'd31, 4'd12, 14'd9999}) || (m_axis_tdata[22:0] == {5'd1, 4'd1, 14'd0}), "range error without clamped date")

    `GDO_ASSERT(a_one_in_work, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item taken while one is in work")

endmodule

bind gregorian_date_offset gdo_port_checks u_gdo_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
